[design/ctt_pkg.sv]
package ctt_pkg;

    localparam int MAX_RESULTS = 3;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [3:0] {
        KIND_NUM     = 4'd0,
        KIND_NAME    = 4'd1,
        KIND_RUN_END = 4'd2,
        KIND_EQUALS  = 4'd3,
        KIND_EQEQ    = 4'd4,
        KIND_PLUS    = 4'd5,
        KIND_MINUS   = 4'd6,
        KIND_MUL     = 4'd7,
        KIND_DIV     = 4'd8,
        KIND_POW     = 4'd9,
        KIND_NEG     = 4'd10,
        KIND_DOT     = 4'd11,
        KIND_EOS     = 4'd12,
        KIND_UNKNOWN = 4'd13
    } t_kind;

    typedef enum logic [1:0] {
        RUN_NONE   = 2'd0,
        RUN_NUMBER = 2'd1,
        RUN_NAME   = 2'd2
    } t_run_mode;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  text;
        logic        first;
    } t_result;

    typedef struct packed {
        logic [1:0]                     count;
        t_result [MAX_RESULTS-1:0]      res;
    } t_bundle;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_name_start(input logic [7:0] c);
        return ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z))
            || (c == CH_UNDER);
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH)
            || (c == CH_CARET) || (c == CH_BANG) || (c == CH_DOT);
    endfunction

    function automatic t_kind op_kind(input logic [7:0] c);
        t_kind k;
        unique case (c)
            CH_PLUS:  k = KIND_PLUS;
            CH_MINUS: k = KIND_MINUS;
            CH_STAR:  k = KIND_MUL;
            CH_SLASH: k = KIND_DIV;
            CH_CARET: k = KIND_POW;
            CH_BANG:  k = KIND_NEG;
            CH_DOT:   k = KIND_DOT;
            default:  k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic logic is_eos(input logic [7:0] c);
        return (c == CH_SEMI) || (c == CH_LF);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
    endfunction

endpackage

[design/char_stream_tokenizer.sv]
// a character beat's results are registered in the bundle queue before they are offered
// one character beat per cycle while the queue is not full; results leave one beat per cycle
// while output is ready, so an item with n results takes n beats and the queue absorbs bursts
// input ready drops only while the bundle queue between front and back is full
// reset (synchronous, active low) clears run, equals and statement-end state and empties the queue
module char_stream_tokenizer #(
    parameter int QUEUE_DEPTH = ctt_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] ch
    input  logic [0:0]  i_s_tuser,   // [0] ch_valid
    input  logic        i_s_tlast,   // end_of_input
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] text_char
    output logic [4:0]  o_m_tuser,   // [3:0] token_kind, [4] token_first
    output logic        o_m_tlast    // last_of_item
);

    logic                   s_accept, s_push, s_pop;
    ctt_pkg::t_bundle       s_bundle, s_head;
    ctt_pkg::t_queue_status s_status;
    ctt_pkg::t_result       s_result;

    assign o_s_tready = !s_status.full;
    assign s_accept   = i_s_tvalid && o_s_tready;

    ctt_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ch           (i_s_tdata),
        .i_ch_valid     (i_s_tuser[0]),
        .i_end_of_input (i_s_tlast),
        .i_accept       (s_accept),
        .o_push         (s_push),
        .o_bundle       (s_bundle)
    );

    ctt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (s_push),
        .i_data   (s_bundle),
        .i_pop    (s_pop),
        .o_head   (s_head),
        .o_status (s_status)
    );

    ctt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (s_head),
        .i_status (s_status),
        .o_pop    (s_pop),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (s_result),
        .o_last   (o_m_tlast)
    );

    assign o_m_tdata = s_result.text;
    assign o_m_tuser = {s_result.first, s_result.kind};

endmodule

[design/ctt_front.sv]
module ctt_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [7:0]         i_ch,
    input  logic               i_ch_valid,
    input  logic               i_end_of_input,
    input  logic               i_accept,
    output logic               o_push,
    output ctt_pkg::t_bundle   o_bundle
);

    ctt_pkg::t_run_mode r_run, n_run, s_run_mid;
    logic               r_eq, n_eq, s_eq_mid;
    logic               r_lse, n_lse, s_lse_mid;
    logic               s_skip_st, s_skip_out, s_cont, s_lse_end;
    ctt_pkg::t_bundle   s_bundle;

    // results beyond the third are dropped, as on a four-result item
    function automatic ctt_pkg::t_bundle add_result(input ctt_pkg::t_bundle b,
                                                    input ctt_pkg::t_kind kind,
                                                    input logic [7:0] text,
                                                    input logic first);
        ctt_pkg::t_bundle r;
        r = b;
        if (b.count < 2'(ctt_pkg::MAX_RESULTS)) begin
            r.res[b.count].kind  = kind;
            r.res[b.count].text  = text;
            r.res[b.count].first = first;
            r.count              = b.count + 2'd1;
        end
        return r;
    endfunction

    assign s_cont = ctt_pkg::is_digit(i_ch)
                  || ((r_run == ctt_pkg::RUN_NAME) && ctt_pkg::is_name_start(i_ch));

    // next state: state after the character, then end of input clears it all
    always_comb begin
        s_run_mid = r_run;
        s_eq_mid  = r_eq;
        s_lse_mid = r_lse;
        s_skip_st = 1'b0;
        if (i_ch_valid) begin
            if (r_eq) begin
                s_eq_mid  = 1'b0;
                s_lse_mid = 1'b0;
                s_skip_st = (i_ch == ctt_pkg::CH_EQUALS);
            end
            if (!s_skip_st && (r_run != ctt_pkg::RUN_NONE)) begin
                if (s_cont) begin
                    s_skip_st = 1'b1;
                end else begin
                    s_run_mid = ctt_pkg::RUN_NONE;
                end
            end
            if (!s_skip_st) begin
                if (ctt_pkg::is_digit(i_ch)) begin
                    s_run_mid = ctt_pkg::RUN_NUMBER;
                    s_lse_mid = 1'b0;
                end else if (ctt_pkg::is_name_start(i_ch)) begin
                    s_run_mid = ctt_pkg::RUN_NAME;
                    s_lse_mid = 1'b0;
                end else if (i_ch == ctt_pkg::CH_EQUALS) begin
                    s_eq_mid = 1'b1;
                end else if (ctt_pkg::is_op(i_ch)) begin
                    s_lse_mid = 1'b0;
                end else if (ctt_pkg::is_eos(i_ch)) begin
                    s_lse_mid = 1'b1;
                end
            end
        end
        if (i_end_of_input) begin
            n_run = ctt_pkg::RUN_NONE;
            n_eq  = 1'b0;
            n_lse = 1'b0;
        end else begin
            n_run = s_run_mid;
            n_eq  = s_eq_mid;
            n_lse = s_lse_mid;
        end
    end

    // results of one beat
    always_comb begin
        s_bundle   = '0;
        s_skip_out = 1'b0;
        s_lse_end  = s_eq_mid ? 1'b0 : s_lse_mid;
        if (i_ch_valid) begin
            if (r_eq) begin
                if (i_ch == ctt_pkg::CH_EQUALS) begin
                    s_bundle   = add_result(s_bundle, ctt_pkg::KIND_EQEQ, 8'd0, 1'b0);
                    s_skip_out = 1'b1;
                end else begin
                    s_bundle = add_result(s_bundle, ctt_pkg::KIND_EQUALS, 8'd0, 1'b0);
                end
            end
            if (!s_skip_out && (r_run != ctt_pkg::RUN_NONE)) begin
                if (s_cont) begin
                    s_bundle = add_result(s_bundle,
                        (r_run == ctt_pkg::RUN_NUMBER) ? ctt_pkg::KIND_NUM : ctt_pkg::KIND_NAME,
                        i_ch, 1'b0);
                    s_skip_out = 1'b1;
                end else begin
                    s_bundle = add_result(s_bundle, ctt_pkg::KIND_RUN_END, 8'd0, 1'b0);
                end
            end
            if (!s_skip_out) begin
                if (ctt_pkg::is_digit(i_ch)) begin
                    s_bundle = add_result(s_bundle, ctt_pkg::KIND_NUM, i_ch, 1'b1);
                end else if (ctt_pkg::is_name_start(i_ch)) begin
                    s_bundle = add_result(s_bundle, ctt_pkg::KIND_NAME, i_ch, 1'b1);
                end else if (i_ch == ctt_pkg::CH_EQUALS) begin
                    s_bundle = s_bundle;
                end else if (ctt_pkg::is_op(i_ch)) begin
                    s_bundle = add_result(s_bundle, ctt_pkg::op_kind(i_ch), 8'd0, 1'b0);
                end else if (ctt_pkg::is_eos(i_ch)) begin
                    // a pending equals just cleared the suppression
                    if (r_eq || !r_lse) begin
                        s_bundle = add_result(s_bundle, ctt_pkg::KIND_EOS, 8'd0, 1'b0);
                    end
                end else if (!ctt_pkg::is_blank(i_ch)) begin
                    s_bundle = add_result(s_bundle, ctt_pkg::KIND_UNKNOWN, i_ch, 1'b0);
                end
            end
        end
        if (i_end_of_input) begin
            if (s_eq_mid) begin
                s_bundle = add_result(s_bundle, ctt_pkg::KIND_EQUALS, 8'd0, 1'b0);
            end
            if (s_run_mid != ctt_pkg::RUN_NONE) begin
                s_bundle = add_result(s_bundle, ctt_pkg::KIND_RUN_END, 8'd0, 1'b0);
            end
            if (!s_lse_end) begin
                s_bundle = add_result(s_bundle, ctt_pkg::KIND_EOS, 8'd0, 1'b0);
            end
        end
    end

    assign o_bundle = s_bundle;
    assign o_push   = i_accept && (s_bundle.count != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= ctt_pkg::RUN_NONE;
            r_eq  <= 1'b0;
            r_lse <= 1'b0;
        end else if (i_accept) begin
            r_run <= n_run;
            r_eq  <= n_eq;
            r_lse <= n_lse;
        end
    end

endmodule

[design/ctt_queue.sv]
module ctt_queue #(
    parameter int DEPTH = ctt_pkg::QUEUE_DEPTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  ctt_pkg::t_bundle        i_data,
    input  logic                    i_pop,
    output ctt_pkg::t_bundle        o_head,
    output ctt_pkg::t_queue_status  o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ctt_pkg::t_bundle   r_slot [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               s_full, s_empty;

    assign s_full   = (r_count == CNT_W'(DEPTH));
    assign s_empty  = (r_count == '0);
    assign o_status = '{full: s_full, empty: s_empty};
    assign o_head   = r_slot[r_rd_ptr];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= bump(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= bump(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !s_full)
        else $error("bundle pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !s_empty)
        else $error("bundle popped from an empty queue");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_empty || s_full) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with fill count");

endmodule

[design/ctt_back.sv]
module ctt_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  ctt_pkg::t_bundle        i_head,
    input  ctt_pkg::t_queue_status  i_status,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_ready,
    output ctt_pkg::t_result        o_result,
    output logic                    o_last
);

    logic [1:0] r_idx;
    logic       s_beat;

    assign o_valid  = !i_status.empty;
    assign o_result = i_head.res[r_idx];
    assign o_last   = (r_idx == (i_head.count - 2'd1));
    assign s_beat   = o_valid && i_ready;
    assign o_pop    = s_beat && o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (s_beat) begin
            r_idx <= o_last ? 2'd0 : r_idx + 2'd1;
        end
    end

    a_idx_in_bundle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_idx < i_head.count))
        else $error("result index beyond bundle count");

endmodule
